/* rtl/rmwc_pkg.sv */
package rmwc_pkg;

  localparam int RAY_TOTAL_DEF  = 240;
  localparam int STEP_LIMIT_DEF = 1000;
  localparam int QUEUE_DEPTH    = 2;

  localparam int IDX_W   = 8;
  localparam int COORD_W = 20;
  localparam int ANG_W   = 16;
  localparam int CFG_W   = 12;
  localparam int TEXW_W  = 11;
  localparam int SIN_W   = 16;
  localparam int POS_W   = 30;
  localparam int SPAN_W  = 27;
  localparam int DIV_NUM_W = 38;
  localparam int CIDX_W  = 3;

  localparam logic [ANG_W-1:0] HALF_FOV   = 16'd5461;
  localparam logic [ANG_W-1:0] QUARTER    = 16'd16384;
  localparam logic [19:0]      HEIGHT_MAX = 20'hFFFFF;
  localparam logic [24:0]      HNUM_SCALE = 25'd26214400;
  localparam logic [11:0]      COLX_MAX   = 12'd4095;
  localparam logic [9:0]       MSTEP_MAX  = 10'd1023;

  typedef enum logic [CIDX_W-1:0] {
    CFG_WALL_LEFT   = 3'd0,
    CFG_WALL_TOP    = 3'd1,
    CFG_WALL_SPAN_X = 3'd2,
    CFG_WALL_SPAN_Y = 3'd3,
    CFG_SCREEN_W    = 3'd4,
    CFG_SCREEN_H    = 3'd5,
    CFG_TEX_WIDTH   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]  wall_left;
    logic [CFG_W-1:0]  wall_top;
    logic [CFG_W-1:0]  wall_span_x;
    logic [CFG_W-1:0]  wall_span_y;
    logic [CFG_W-1:0]  screen_w;
    logic [CFG_W-1:0]  screen_h;
    logic [TEXW_W-1:0] tex_width;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   ray_index;
    logic [COORD_W-1:0] player_x;
    logic [COORD_W-1:0] player_y;
    logic [ANG_W-1:0]   player_heading;
    logic [19:0]        colx_num;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic               wall_hit;
    logic [9:0]         march_steps;
    logic [11:0]        column_x;
    logic signed [19:0] column_top;
    logic [19:0]        column_height;
    logic               side_vertical;
    logic [10:0]        texture_column;
  } res_t;

endpackage

/* rtl/rmwc_front.sv */
module rmwc_front import rmwc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   ray_index,
  input  logic [COORD_W-1:0] player_x,
  input  logic [COORD_W-1:0] player_y,
  input  logic [ANG_W-1:0]   player_heading,
  input  q_stat_t            q_stat,
  output logic               push,
  output req_t               push_data
);

  logic held;
  req_t item;
  logic take;

  assign in_stall  = held & q_stat.full;
  assign take      = in_valid & ~in_stall;
  assign push      = held & ~q_stat.full;
  assign push_data = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= take | (held & q_stat.full);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.ray_index      <= ray_index;
      item.player_x       <= player_x;
      item.player_y       <= player_y;
      item.player_heading <= player_heading;
      item.colx_num       <= 20'(ray_index) * 20'(cfg.screen_w);
    end
  end

endmodule

/* rtl/rmwc_queue.sv */
module rmwc_queue import rmwc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  req_t    push_data,
  input  logic    pop,
  output req_t    pop_data,
  output q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  req_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/rmwc_div.sv */
module rmwc_div #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem, quot[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      rem  <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

/* rtl/rmwc_back.sv */
module rmwc_back import rmwc_pkg::*; #(
  parameter int RAY_TOTAL  = RAY_TOTAL_DEF,
  parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  q_stat_t q_stat,
  input  req_t    pop_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_stall,
  output res_t    res
);

  localparam int STEP_W    = $clog2(STEP_LIMIT + 1);
  localparam int HDEN_W    = STEP_W + 15;
  localparam int DIV_DEN_W = (HDEN_W > SPAN_W) ? HDEN_W : SPAN_W;
  localparam int SPREAD_SH = 37;
  localparam int COLX_SH   = 31;
  localparam longint unsigned SPREAD_MUL =
    (longint'(1) << SPREAD_SH) / longint'(6 * RAY_TOTAL) + 1;
  localparam longint unsigned COLX_MUL =
    (longint'(1) << COLX_SH) / longint'(RAY_TOTAL) + 1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_SPREAD = 12'b000000000010,
    S_SINE   = 12'b000000000100,
    S_MARCH  = 12'b000000001000,
    S_COLX   = 12'b000000010000,
    S_HSTART = 12'b000000100000,
    S_HDIV   = 12'b000001000000,
    S_EDGE1  = 12'b000010000000,
    S_EDGE2  = 12'b000100000000,
    S_TSTART = 12'b001000000000,
    S_TEX    = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state;
  req_t   req;

  logic [ANG_W-1:0] off;
  logic [ANG_W-1:0] ang;
  logic [ANG_W-1:0] sarg;
  logic [1:0]       sk;
  logic [2:0]       sph;
  logic [14:0]      sx;
  logic [14:0]      sx2;
  logic [16:0]      stt;
  logic             sneg;
  logic [16:0]      ma;
  logic [14:0]      mb;
  logic [31:0]      prod;
  logic [16:0]      sraw;
  logic [14:0]      smag;
  logic signed [SIN_W-1:0] sval;

  logic signed [SIN_W-1:0] dx;
  logic signed [SIN_W-1:0] dy;
  logic signed [SIN_W-1:0] cosoff;

  logic signed [POS_W-1:0] px, py, lft, rgt, tp, bt;
  logic signed [POS_W-1:0] nx, ny;
  logic signed [POS_W-1:0] dl, dr, dt, db, nv;
  logic [POS_W-1:0]        adl, adr, adt, adb, minx, miny;
  logic [STEP_W-1:0]       steps;
  logic [STEP_W-1:0]       steps_next;
  logic                    in_rect;
  logic                    march_end;
  logic                    hit;
  logic                    vert;
  logic [11:0]             colx;
  logic [19:0]             hgt;
  logic [SPAN_W-1:0]       tnum;
  logic [SPAN_W-1:0]       tden;
  logic [SPAN_W-1:0]       den27;
  logic [10:0]             tex;
  logic [43:0]             spread_prod;
  logic [51:0]             colx_prod;
  logic [20:0]             colx_quot;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic                 load_out;

  rmwc_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .done (div_done),
    .quot (div_quot)
  );

  assign ang = req.player_heading + off;

  assign spread_prod = 44'(req.ray_index) * 44'(SPREAD_MUL);
  assign colx_prod   = 52'(req.colx_num) * 52'(COLX_MUL);
  assign colx_quot   = colx_prod[51:COLX_SH];

  always_comb begin
    unique case (sk)
      2'd0:    sarg = ang;
      2'd1:    sarg = ang + QUARTER;
      default: sarg = off + QUARTER;
    endcase
  end

  always_comb begin
    unique case (sph)
      3'd1:    begin ma = {2'b00, sx}; mb = sx;  end
      3'd2:    begin ma = 17'd4640;    mb = sx2; end
      3'd3:    begin ma = stt;         mb = sx2; end
      3'd4:    begin ma = stt;         mb = sx;  end
      default: begin ma = '0;          mb = '0;  end
    endcase
  end

  assign prod = 32'(ma) * 32'(mb);
  assign sraw = prod[31:15];
  assign smag = (sraw > 17'd32767) ? 15'd32767 : sraw[14:0];
  assign sval = sneg ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  assign nx         = px + POS_W'(dx);
  assign ny         = py + POS_W'(dy);
  assign steps_next = steps + 1'b1;
  assign in_rect    = (nx >= lft) && (nx < rgt) && (ny >= tp) && (ny < bt);
  assign march_end  = in_rect || (steps_next == STEP_W'(STEP_LIMIT));

  assign dl = px - lft;
  assign dr = px - rgt;
  assign dt = py - tp;
  assign db = py - bt;
  assign minx  = (adr < adl) ? adr : adl;
  assign miny  = (adb < adt) ? adb : adt;
  assign nv    = (minx < miny) ? dt : dl;
  assign den27 = (minx < miny) ? {cfg.wall_span_y, 15'd0} : {cfg.wall_span_x, 15'd0};

  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_HSTART: begin
        div_start = (cosoff > 0);
        div_num   = DIV_NUM_W'(37'(cfg.screen_h) * 37'(HNUM_SCALE));
        div_den   = DIV_DEN_W'(HDEN_W'(steps) * HDEN_W'(cosoff[14:0]));
      end
      S_TSTART: begin
        div_start = (tden != '0);
        div_num   = DIV_NUM_W'(tnum) * DIV_NUM_W'(cfg.tex_width);
        div_den   = DIV_DEN_W'(tden);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sk        <= '0;
      sph       <= '0;
    end else begin
      out_valid <= load_out | (out_valid & out_stall);
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) state <= S_SPREAD;
        end
        S_SPREAD: begin
          state <= S_SINE;
          sk    <= '0;
          sph   <= '0;
        end
        S_SINE: begin
          if (sph == 3'd4) begin
            sph <= '0;
            if (sk == 2'd2) state <= S_MARCH;
            else sk <= sk + 1'b1;
          end else begin
            sph <= sph + 1'b1;
          end
        end
        S_MARCH: begin
          if (march_end) state <= S_COLX;
        end
        S_COLX: begin
          state <= hit ? S_HSTART : S_OUT;
        end
        S_HSTART: begin
          state <= div_start ? S_HDIV : S_EDGE1;
        end
        S_HDIV: begin
          if (div_done) state <= S_EDGE1;
        end
        S_EDGE1: state <= S_EDGE2;
        S_EDGE2: state <= S_TSTART;
        S_TSTART: begin
          state <= div_start ? S_TEX : S_OUT;
        end
        S_TEX: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) req <= pop_data;
    if (state == S_SPREAD) off <= spread_prod[SPREAD_SH-1:SPREAD_SH-16] - HALF_FOV;
    if (state == S_SINE) begin
      unique case (sph)
        3'd0: begin
          sx   <= sarg[14] ? 15'(QUARTER - {2'b00, sarg[13:0]}) : {1'b0, sarg[13:0]};
          sneg <= sarg[15];
        end
        3'd1: sx2 <= prod[28:14];
        3'd2: stt <= 17'd42047 - 17'(prod[31:14]);
        3'd3: stt <= 17'd102944 - 17'(prod[31:14]);
        default: begin
          unique case (sk)
            2'd0:    dy     <= sval;
            2'd1:    dx     <= sval;
            default: cosoff <= sval;
          endcase
        end
      endcase
      if (sph == 3'd4 && sk == 2'd2) begin
        px    <= $signed({3'b000, req.player_x, 7'd0});
        py    <= $signed({3'b000, req.player_y, 7'd0});
        lft   <= $signed({3'b000, cfg.wall_left, 15'd0});
        tp    <= $signed({3'b000, cfg.wall_top, 15'd0});
        rgt   <= $signed({2'b00, 13'({1'b0, cfg.wall_left} + {1'b0, cfg.wall_span_x}), 15'd0});
        bt    <= $signed({2'b00, 13'({1'b0, cfg.wall_top} + {1'b0, cfg.wall_span_y}), 15'd0});
        steps <= '0;
        hit   <= 1'b0;
      end
    end
    if (state == S_MARCH) begin
      px    <= nx;
      py    <= ny;
      steps <= steps_next;
      if (in_rect) hit <= 1'b1;
    end
    if (state == S_COLX) begin
      colx <= (colx_quot > 21'(COLX_MAX)) ? COLX_MAX : colx_quot[11:0];
    end
    if (state == S_HSTART && !div_start) hgt <= HEIGHT_MAX;
    if (state == S_HDIV && div_done) begin
      hgt <= (div_quot > DIV_NUM_W'(HEIGHT_MAX)) ? HEIGHT_MAX : div_quot[19:0];
    end
    if (state == S_EDGE1) begin
      adl <= dl[POS_W-1] ? POS_W'(-dl) : POS_W'(dl);
      adr <= dr[POS_W-1] ? POS_W'(-dr) : POS_W'(dr);
      adt <= dt[POS_W-1] ? POS_W'(-dt) : POS_W'(dt);
      adb <= db[POS_W-1] ? POS_W'(-db) : POS_W'(db);
    end
    if (state == S_EDGE2) begin
      vert <= (minx < miny);
      tden <= den27;
      if (nv < 0) tnum <= '0;
      else if ($unsigned(nv) > POS_W'(den27)) tnum <= den27;
      else tnum <= nv[SPAN_W-1:0];
    end
    if (state == S_TSTART && !div_start) tex <= '0;
    if (state == S_TEX && div_done) tex <= div_quot[10:0];
    if (load_out) begin
      res.wall_hit    <= hit;
      res.march_steps <= (32'(steps) > 32'(MSTEP_MAX)) ? MSTEP_MAX : 10'(steps);
      res.column_x    <= colx;
      if (hit) begin
        res.column_top     <= $signed(20'({9'd0, cfg.screen_h} * 21'd8
                                          - ((21'(hgt) + 21'd1) >> 1)));
        res.column_height  <= hgt;
        res.side_vertical  <= vert;
        res.texture_column <= tex;
      end else begin
        res.column_top     <= '0;
        res.column_height  <= '0;
        res.side_vertical  <= 1'b0;
        res.texture_column <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARCH) |-> (32'(steps) < 32'(STEP_LIMIT)))
    else $error("march ran past step limit");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_HDIV || state == S_TEX))
    else $error("divider result in a state that does not wait for it");
`endif

endmodule

/* rtl/ray_march_wall_column_core.sv */
// One ray request in, one wall column result out. The back end marches the ray one pixel per
// clock and shares a single one-bit-per-clock divider for the wall height and texture
// column; the ray spread and column x come from reciprocal products, and three sine
// evaluations run one after another. A front register and a two-entry queue take new
// requests while the back end works and while a finished result waits in the output register.
module ray_march_wall_column_core import rmwc_pkg::*; #(
  parameter int RAY_TOTAL  = RAY_TOTAL_DEF,
  parameter int STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   ray_index,
  input  logic [COORD_W-1:0] player_x,
  input  logic [COORD_W-1:0] player_y,
  input  logic [ANG_W-1:0]   player_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               wall_hit,
  output logic [9:0]         march_steps,
  output logic [11:0]        column_x,
  output logic signed [19:0] column_top,
  output logic [19:0]        column_height,
  output logic               side_vertical,
  output logic [10:0]        texture_column
);

  cfg_t    cfg;
  q_stat_t q_stat;
  logic    push;
  req_t    push_data;
  logic    pop;
  req_t    pop_data;
  res_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_left   <= 12'd500;
      cfg.wall_top    <= 12'd150;
      cfg.wall_span_x <= 12'd64;
      cfg.wall_span_y <= 12'd64;
      cfg.screen_w    <= 12'd800;
      cfg.screen_h    <= 12'd600;
      cfg.tex_width   <= 11'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WALL_LEFT:   cfg.wall_left   <= cfg_data;
        CFG_WALL_TOP:    cfg.wall_top    <= cfg_data;
        CFG_WALL_SPAN_X: cfg.wall_span_x <= cfg_data;
        CFG_WALL_SPAN_Y: cfg.wall_span_y <= cfg_data;
        CFG_SCREEN_W:    cfg.screen_w    <= cfg_data;
        CFG_SCREEN_H:    cfg.screen_h    <= cfg_data;
        CFG_TEX_WIDTH:   cfg.tex_width   <= cfg_data[TEXW_W-1:0];
        default: ;
      endcase
    end
  end

  rmwc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ray_index     (ray_index),
    .player_x      (player_x),
    .player_y      (player_y),
    .player_heading(player_heading),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  rmwc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .q_stat   (q_stat)
  );

  rmwc_back #(
    .RAY_TOTAL (RAY_TOTAL),
    .STEP_LIMIT(STEP_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res      (res)
  );

  assign wall_hit       = res.wall_hit;
  assign march_steps    = res.march_steps;
  assign column_x       = res.column_x;
  assign column_top     = res.column_top;
  assign column_height  = res.column_height;
  assign side_vertical  = res.side_vertical;
  assign texture_column = res.texture_column;

endmodule

/* test/ray_march_wall_column_core_test.sv */
module ray_march_wall_column_core_test;
  import rmwc_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [IDX_W-1:0]   ray_index = '0;
  logic [COORD_W-1:0] player_x = '0;
  logic [COORD_W-1:0] player_y = '0;
  logic [ANG_W-1:0]   player_heading = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               wall_hit;
  logic [9:0]         march_steps;
  logic [11:0]        column_x;
  logic signed [19:0] column_top;
  logic [19:0]        column_height;
  logic               side_vertical;
  logic [10:0]        texture_column;

  ray_march_wall_column_core u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .ray_index(ray_index), .player_x(player_x), .player_y(player_y),
    .player_heading(player_heading), .out_valid(out_valid), .out_stall(out_stall),
    .wall_hit(wall_hit), .march_steps(march_steps), .column_x(column_x),
    .column_top(column_top), .column_height(column_height),
    .side_vertical(side_vertical), .texture_column(texture_column)
  );

  cfg_t wall_cfg;
  res_t column_q[$];
  int   fail_cnt = 0;
  int   burst_left = 0;
  int   hold_off_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint quarter_wave(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 14;
    t = (4640 * x2) >> 14;
    t = 42047 - t;
    t = (t * x2) >> 14;
    t = 102944 - t;
    t = (t * x) >> 15;
    if (t > 32767) t = 32767;
    return longint'(t);
  endfunction

  function automatic longint sin_q15(logic [15:0] a);
    longint v;
    if (a[14]) v = quarter_wave(16384 - a[13:0]);
    else v = quarter_wave(a[13:0]);
    return a[15] ? -v : v;
  endfunction

  function automatic longint cos_q15(logic [15:0] a);
    logic [15:0] s;
    s = a + QUARTER;
    return sin_q15(s);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic res_t march_ray(logic [7:0] idx, logic [19:0] x0, logic [19:0] y0,
                                     logic [15:0] hd);
    res_t r;
    logic [15:0] off, ang;
    longint px, py, dx, dy, l, rt, t, b, steps, colx, c, h, minx, miny, num, den, tex;
    longint sh;
    bit hit, vert;
    off = 16'(longint'(idx) * 65536 / 1440 + 65536 - 5461);
    ang = hd + off;
    dx = cos_q15(ang);
    dy = sin_q15(ang);
    px = longint'(x0) << 7;
    py = longint'(y0) << 7;
    l = longint'(wall_cfg.wall_left) << 15;
    rt = (longint'(wall_cfg.wall_left) + longint'(wall_cfg.wall_span_x)) << 15;
    t = longint'(wall_cfg.wall_top) << 15;
    b = (longint'(wall_cfg.wall_top) + longint'(wall_cfg.wall_span_y)) << 15;
    steps = 0;
    hit = 0;
    while (steps < 1000 && !hit) begin
      px += dx;
      py += dy;
      steps++;
      if (px >= l && px < rt && py >= t && py < b) hit = 1;
    end
    colx = longint'(idx) * longint'(wall_cfg.screen_w) / 240;
    if (colx > 4095) colx = 4095;
    r = '0;
    r.wall_hit = hit;
    r.march_steps = steps > 1023 ? 10'd1023 : 10'(steps);
    r.column_x = 12'(colx);
    if (hit) begin
      sh = longint'(wall_cfg.screen_h);
      c = cos_q15(off);
      if (c <= 0) h = 1048575;
      else begin
        h = sh * 800 * 32768 / (steps * c);
        if (h > 1048575) h = 1048575;
      end
      minx = mag(px - l);
      if (mag(px - rt) < minx) minx = mag(px - rt);
      miny = mag(py - t);
      if (mag(py - b) < miny) miny = mag(py - b);
      vert = minx < miny;
      if (vert) begin
        num = py - t;
        den = longint'(wall_cfg.wall_span_y) << 15;
      end else begin
        num = px - l;
        den = longint'(wall_cfg.wall_span_x) << 15;
      end
      if (num < 0) num = 0;
      if (num > den) num = den;
      tex = 0;
      if (den != 0) tex = num * longint'(wall_cfg.tex_width) / den;
      r.column_top = 20'(sh * 8 - ((h + 1) >> 1));
      r.column_height = 20'(h);
      r.side_vertical = vert;
      r.texture_column = 11'(tex);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (column_q.size() == 0) begin
        $error("result transfer with no request pending");
        fail_cnt++;
      end else begin
        e = column_q.pop_front();
        if (wall_hit !== e.wall_hit) begin
          $error("wall_hit exp %0d got %0d", e.wall_hit, wall_hit); fail_cnt++;
        end
        if (march_steps !== e.march_steps) begin
          $error("march_steps exp %0d got %0d", e.march_steps, march_steps); fail_cnt++;
        end
        if (column_x !== e.column_x) begin
          $error("column_x exp %0d got %0d", e.column_x, column_x); fail_cnt++;
        end
        if (column_top !== e.column_top) begin
          $error("column_top exp %0d got %0d", e.column_top, column_top); fail_cnt++;
        end
        if (column_height !== e.column_height) begin
          $error("column_height exp %0d got %0d", e.column_height, column_height);
          fail_cnt++;
        end
        if (side_vertical !== e.side_vertical) begin
          $error("side_vertical exp %0d got %0d", e.side_vertical, side_vertical);
          fail_cnt++;
        end
        if (texture_column !== e.texture_column) begin
          $error("texture_column exp %0d got %0d", e.texture_column, texture_column);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(200, 3000);
      end
      left--;
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else if (mode == 0) out_stall <= 1'b0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_ray(int idx, int x, int y, int hd);
    in_valid <= 1'b1;
    ray_index <= 8'(idx);
    player_x <= 20'(x);
    player_y <= 20'(y);
    player_heading <= 16'(hd);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    column_q.push_back(march_ray(8'(idx), 20'(x), 20'(y), 16'(hd)));
    if (burst_left > 0) burst_left--;
    else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(100, 1500) : $urandom_range(1, 12))
        @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (column_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t r, int v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= 12'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (r)
      CFG_WALL_LEFT:   wall_cfg.wall_left = 12'(v);
      CFG_WALL_TOP:    wall_cfg.wall_top = 12'(v);
      CFG_WALL_SPAN_X: wall_cfg.wall_span_x = 12'(v);
      CFG_WALL_SPAN_Y: wall_cfg.wall_span_y = 12'(v);
      CFG_SCREEN_W:    wall_cfg.screen_w = 12'(v);
      CFG_SCREEN_H:    wall_cfg.screen_h = 12'(v);
      CFG_TEX_WIDTH:   wall_cfg.tex_width = 11'(v);
      default: ;
    endcase
  endtask

  task automatic set_all(int l, int t, int sx, int sy, int sw, int sh, int tw);
    set_reg(CFG_WALL_LEFT, l);
    set_reg(CFG_WALL_TOP, t);
    set_reg(CFG_WALL_SPAN_X, sx);
    set_reg(CFG_WALL_SPAN_Y, sy);
    set_reg(CFG_SCREEN_W, sw);
    set_reg(CFG_SCREEN_H, sh);
    set_reg(CFG_TEX_WIDTH, tw);
  endtask

  // aim at the wall from one of its four sides, with random offsets
  task automatic send_aimed;
    int dir, d, sx, sy, x, y, hd, idx;
    dir = $urandom_range(0, 3);
    d = $urandom_range(2, 400);
    sx = wall_cfg.wall_span_x == 0 ? 1 : int'(wall_cfg.wall_span_x);
    sy = wall_cfg.wall_span_y == 0 ? 1 : int'(wall_cfg.wall_span_y);
    x = (int'(wall_cfg.wall_left) + $urandom_range(0, sx - 1)) * 256;
    y = (int'(wall_cfg.wall_top) + $urandom_range(0, sy - 1)) * 256;
    case (dir)
      0: x = (int'(wall_cfg.wall_left) - d) * 256;
      1: y = (int'(wall_cfg.wall_top) - d) * 256;
      2: x = (int'(wall_cfg.wall_left) + sx + d) * 256;
      default: y = (int'(wall_cfg.wall_top) + sy + d) * 256;
    endcase
    x += $urandom_range(0, 255);
    y += $urandom_range(0, 255);
    hd = dir * 16384 + $urandom_range(0, 4000) - 2000;
    idx = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 239);
    send_ray(idx, x, y, hd);
  endtask

  task automatic send_noise;
    send_ray($urandom_range(0, 255), $urandom_range(0, 20'hFFFFF),
             $urandom_range(0, 20'hFFFFF), $urandom_range(0, 16'hFFFF));
  endtask

  task automatic test_defaults;
    send_ray(0, 450 * 256, 182 * 256, 0);
    send_ray(120, 450 * 256, 182 * 256, 0);
    send_ray(239, 450 * 256, 182 * 256, 0);
    send_ray(240, 450 * 256, 182 * 256, 0);
    send_ray(255, 450 * 256, 182 * 256, 0);
    send_ray(120, 532 * 256, 100 * 256, 16384);
    send_ray(120, 620 * 256, 182 * 256, 32768);
    send_ray(120, 532 * 256, 260 * 256, 49152);
    send_ray(0, 0, 0, 0);
    send_ray(255, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_ray(17, 0, 20'hFFFFF, 16'h8000);
    drain();
  endtask

  task automatic test_config_extremes;
    set_all(0, 0, 4095, 4095, 4095, 4095, 1024);
    send_ray(120, 1000 * 256, 1000 * 256, 0);
    send_ray(255, 0, 0, 16'hFFFF);
    send_ray(0, 20'hFFFFF, 20'hFFFFF, 32768);
    drain();
    set_all(100, 100, 0, 0, 1, 1, 0);
    send_ray(120, 50 * 256, 100 * 256, 0);
    send_ray(0, 100 * 256, 100 * 256, 0);
    drain();
    set_all(10, 10, 40, 40, 4095, 4095, 0);
    send_ray(120, 2 * 256, 30 * 256, 0);
    drain();
    set_all(4095, 4095, 1, 1, 640, 480, 1);
    send_ray(120, 4090 * 256, 4095 * 256 + 128, 0);
    send_ray(120, 4095 * 256 + 128, 4090 * 256, 16384);
    drain();
  endtask

  task automatic test_random_phases;
    for (int p = 0; p < 5; p++) begin
      drain();
      set_all($urandom_range(0, 4000), $urandom_range(0, 4000),
              $urandom_range(0, 3) == 0 ? $urandom_range(1, 4095) : $urandom_range(1, 200),
              $urandom_range(0, 3) == 0 ? $urandom_range(1, 4095) : $urandom_range(1, 200),
              $urandom_range(1, 4095), $urandom_range(1, 4095),
              $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 1 : 1024)
                                        : $urandom_range(1, 1024));
      for (int i = 0; i < 106; i++) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_aimed();
      end
    end
    drain();
  endtask

  task automatic test_backpressure;
    set_all(500, 150, 64, 64, 800, 600, 64);
    hold_off_cycles = 9000;
    for (int i = 0; i < 10; i++) send_aimed();
    drain();
    for (int i = 0; i < 10; i++) send_aimed();
    drain();
  endtask

  initial begin
    wall_cfg.wall_left = 12'd500;
    wall_cfg.wall_top = 12'd150;
    wall_cfg.wall_span_x = 12'd64;
    wall_cfg.wall_span_y = 12'd64;
    wall_cfg.screen_w = 12'd800;
    wall_cfg.screen_h = 12'd600;
    wall_cfg.tex_width = 11'd64;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    drain();
    repeat (300) @(posedge clk);
    if (fail_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
